[rtl/core/armik_pkg.sv]
// Shared types and constants for the arm inverse kinematics pipeline.
// Holds the transaction structs, the CORDIC arctangent table and the fixed-point formats.
// No dependencies.
package armik_pkg;

    // Requested number of CORDIC micro-rotations. The table covers at most 24.
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int NUM_STAGES    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    // Fixed-point formats.
    localparam int FRAC_BITS = 8;            // extra fraction bits on x and y
    localparam int XY_W      = 28;           // signed width of the CORDIC x and y
    localparam int ACC_W     = 32;           // signed angle accumulator, 1/100 deg * 2^16
    localparam int ANG_SHIFT = 16;           // fraction bits of the accumulator
    localparam int GAIN_W    = 16;
    localparam logic [GAIN_W-1:0] GAIN_INV = 16'd39797;
    localparam int MAG_W     = XY_W - 1;     // non-negative final x
    localparam int PROD_W    = MAG_W + GAIN_W;
    localparam int RAD_SHIFT = 16 + FRAC_BITS;
    localparam int RAD_W     = PROD_W - RAD_SHIFT + 1;
    localparam int ANG_W     = ACC_W + 1 - ANG_SHIFT;

    localparam logic signed [ACC_W-1:0] ACC_HALF_TURN = 32'sd1179648000;
    localparam logic [15:0] FULL_TURN = 16'd36000;

    // Register map, word index into the configuration space.
    localparam logic [1:0] REG_ARM_BASE   = 2'd0;
    localparam logic [1:0] REG_MAX_LIFT   = 2'd1;
    localparam logic [1:0] REG_MAX_STRETCH = 2'd2;
    localparam int CFG_ADDR_W = 4;

    // round(atan(2^-i) * 18000 / pi * 2^16)
    localparam logic signed [ACC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
        32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
        32'sd1466764,   32'sd733389,    32'sd366693,   32'sd183346,
        32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
        32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
        32'sd358,       32'sd179,       32'sd90,       32'sd45
    };

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] target_z;
        logic signed [15:0] pitch_request;
        logic [15:0]        current_rotate_angle;
    } t_ik_in;

    typedef struct packed {
        logic [15:0]        rotate_target;
        logic [14:0]        stretch_target;
        logic [14:0]        lift_target;
        logic signed [15:0] pitch_target;
        logic               held_singular;
    } t_ik_out;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [14:0] arm_base_length;
        logic [14:0] max_lift_height;
        logic [14:0] max_stretch_length;
    } t_cfg;

    // Vector state of one CORDIC stage.
    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ACC_W-1:0] acc;
    } t_cordic;

    // Fields that ride alongside the CORDIC untouched.
    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] pitch;
        logic [15:0]        cur;
        logic               held;
    } t_side;

endpackage

[rtl/core/armik_regs.sv]
// APB configuration registers: arm base length and the two clamp limits.
// Depends on armik_pkg.
module armik_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [armik_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output armik_pkg::t_cfg                    o_cfg
);
    import armik_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    // Register writes; an address past the map is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arm_base_length    <= 15'd0;
            r_cfg.max_lift_height    <= 15'h7fff;
            r_cfg.max_stretch_length <= 15'h7fff;
        end else if (w_wr) begin
            case (w_idx)
                REG_ARM_BASE:    r_cfg.arm_base_length    <= pwdata[14:0];
                REG_MAX_LIFT:    r_cfg.max_lift_height    <= pwdata[14:0];
                REG_MAX_STRETCH: r_cfg.max_stretch_length <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        case (w_idx)
            REG_ARM_BASE:    prdata = {17'd0, r_cfg.arm_base_length};
            REG_MAX_LIFT:    prdata = {17'd0, r_cfg.max_lift_height};
            REG_MAX_STRETCH: prdata = {17'd0, r_cfg.max_stretch_length};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/armik_cordic.sv]
// Pipelined CORDIC in vectoring mode: a pre-rotation register, then one register per
// micro-rotation. Side fields travel with each stage. Depends on armik_pkg.
module armik_cordic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  armik_pkg::t_ik_in   i_cmd,
    output logic                o_valid,
    output armik_pkg::t_cordic  o_vec,
    output armik_pkg::t_side    o_side
);
    import armik_pkg::*;

    logic    r_valid [NUM_STAGES+1];
    t_cordic r_vec   [NUM_STAGES+1];
    t_side   r_side  [NUM_STAGES+1];

    logic signed [XY_W-1:0] w_x_in;
    logic signed [XY_W-1:0] w_y_in;
    t_cordic                n_vec0;
    t_side                  n_side0;

    // Pre-rotation: targets in the left half plane are turned by 180 degrees.
    assign w_x_in = XY_W'(i_cmd.target_x) <<< FRAC_BITS;
    assign w_y_in = XY_W'(i_cmd.target_y) <<< FRAC_BITS;

    always_comb begin
        if (i_cmd.target_x[15]) begin
            n_vec0.x   = -w_x_in;
            n_vec0.y   = -w_y_in;
            n_vec0.acc = ACC_HALF_TURN;
        end else begin
            n_vec0.x   = w_x_in;
            n_vec0.y   = w_y_in;
            n_vec0.acc = '0;
        end
        n_side0.z     = i_cmd.target_z;
        n_side0.pitch = i_cmd.pitch_request;
        n_side0.cur   = i_cmd.current_rotate_angle;
        n_side0.held  = (i_cmd.target_x == 16'sd0) && (i_cmd.target_y == 16'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec[0]  <= n_vec0;
        r_side[0] <= n_side0;
    end

    // One micro-rotation per stage, shifting by the stage index.
    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        logic signed [XY_W-1:0] w_x;
        logic signed [XY_W-1:0] w_y;
        logic signed [XY_W-1:0] w_dx;
        logic signed [XY_W-1:0] w_dy;
        t_cordic                n_vec;

        assign w_x  = r_vec[s].x;
        assign w_y  = r_vec[s].y;
        assign w_dx = w_y >>> s;
        assign w_dy = w_x >>> s;

        always_comb begin
            if (!w_y[XY_W-1]) begin
                n_vec.x   = w_x + w_dx;
                n_vec.y   = w_y - w_dy;
                n_vec.acc = r_vec[s].acc + ATAN_TAB[s];
            end else begin
                n_vec.x   = w_x - w_dx;
                n_vec.y   = w_y + w_dy;
                n_vec.acc = r_vec[s].acc - ATAN_TAB[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else begin
                r_valid[s+1] <= r_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_vec[s+1]  <= n_vec;
            r_side[s+1] <= r_side[s];
        end
    end

    assign o_valid = r_valid[NUM_STAGES];
    assign o_vec   = r_vec[NUM_STAGES];
    assign o_side  = r_side[NUM_STAGES];

endmodule

[rtl/core/armik_post.sv]
// Post-processing after the CORDIC: gain correction multiply, angle rounding and wrap,
// stretch and lift clamps. Two register stages, the last one is the output register.
// Depends on armik_pkg.
module armik_post (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  armik_pkg::t_cordic  i_vec,
    input  armik_pkg::t_side    i_side,
    input  armik_pkg::t_cfg     i_cfg,
    output logic                o_valid,
    output armik_pkg::t_ik_out  o_result
);
    import armik_pkg::*;

    // Stage A registers.
    logic                     r_a_valid;
    logic [PROD_W-1:0]        r_a_prod;
    logic signed [ANG_W-1:0]  r_a_ang;
    logic [15:0]              r_a_cur;
    logic [14:0]              r_a_lift;
    logic signed [15:0]       r_a_pitch;
    logic                     r_a_held;

    // Stage B (output) registers.
    logic    r_b_valid;
    t_ik_out r_b_out;

    logic [MAG_W-1:0]         w_mag;
    logic signed [ACC_W:0]    w_acc_rnd;
    logic signed [ANG_W-1:0]  n_a_ang;
    logic [PROD_W-1:0]        n_a_prod;
    logic [15:0]              n_a_cur;
    logic [14:0]              n_a_lift;

    // Stage A: gain multiply, angle rounding, held-angle reduction, lift clamp.
    assign w_mag     = i_vec.x[XY_W-1] ? '0 : i_vec.x[MAG_W-1:0];
    assign n_a_prod  = PROD_W'(w_mag) * PROD_W'(GAIN_INV);
    assign w_acc_rnd = (ACC_W+1)'(i_vec.acc) + (ACC_W+1)'(1 << (ANG_SHIFT - 1));
    assign n_a_ang   = ANG_W'(w_acc_rnd >>> ANG_SHIFT);
    assign n_a_cur   = (i_side.cur >= FULL_TURN) ? i_side.cur - FULL_TURN : i_side.cur;

    always_comb begin
        if (i_side.z[15]) begin
            n_a_lift = 15'd0;
        end else if (i_side.z[14:0] > i_cfg.max_lift_height) begin
            n_a_lift = i_cfg.max_lift_height;
        end else begin
            n_a_lift = i_side.z[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_prod  <= n_a_prod;
        r_a_ang   <= n_a_ang;
        r_a_cur   <= n_a_cur;
        r_a_lift  <= n_a_lift;
        r_a_pitch <= i_side.pitch;
        r_a_held  <= i_side.held;
    end

    // Stage B: radius rounding, stretch clamp, angle wrap and the held-angle select.
    logic [RAD_W-1:0]          w_radius;
    logic signed [RAD_W+1:0]   w_stretch;
    logic signed [ANG_W:0]     w_ang;
    logic signed [ANG_W:0]     w_turn;
    t_ik_out                   n_b_out;

    assign w_radius  = RAD_W'((r_a_prod + PROD_W'(1 << (RAD_SHIFT - 1))) >> RAD_SHIFT);
    assign w_stretch = $signed({2'b00, w_radius}) - $signed((RAD_W+2)'(i_cfg.arm_base_length));
    assign w_turn    = (ANG_W+1)'(FULL_TURN);

    always_comb begin
        w_ang = (ANG_W+1)'(r_a_ang);
        if (w_ang < 0) begin
            w_ang = w_ang + w_turn;
        end else if (w_ang >= w_turn) begin
            w_ang = w_ang - w_turn;
        end

        n_b_out.rotate_target = r_a_held ? r_a_cur : w_ang[15:0];
        if (w_stretch < 0) begin
            n_b_out.stretch_target = 15'd0;
        end else if (w_stretch > $signed((RAD_W+2)'(i_cfg.max_stretch_length))) begin
            n_b_out.stretch_target = i_cfg.max_stretch_length;
        end else begin
            n_b_out.stretch_target = w_stretch[14:0];
        end
        n_b_out.lift_target   = r_a_lift;
        n_b_out.pitch_target  = r_a_pitch;
        n_b_out.held_singular = r_a_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_out <= n_b_out;
    end

    assign o_valid  = r_b_valid;
    assign o_result = r_b_out;

endmodule

[rtl/core/cartesian_to_arm_joint_targets.sv]
// Top level of the arm inverse kinematics block: APB registers, CORDIC pipeline, post stage.
// Depends on armik_pkg, armik_regs, armik_cordic and armik_post.
//
//   Channel   Direction  Handshake                 Payload
//   command   in         start (busy is tied low)  i_cmd    (t_ik_in)
//   result    out        o_done strobe, one cycle  o_result (t_ik_out)
//   config    in/out     APB psel/penable/pwrite   pwdata, prdata, paddr
//
// One transaction is accepted every cycle; each result passes through one pre-rotation
// register, one register per CORDIC micro-rotation, then a multiply stage and the output
// register.
// Reset clears only the valid bits and the configuration registers.
// The receiver takes every result in its strobe cycle, so nothing ever stalls.
module cartesian_to_arm_joint_targets (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  armik_pkg::t_ik_in                 i_cmd,
    output logic                              o_done,
    output armik_pkg::t_ik_out                o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [armik_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import armik_pkg::*;

    t_cfg    w_cfg;
    logic    w_cordic_valid;
    t_cordic w_cordic_vec;
    t_side   w_cordic_side;

    // The pipeline takes a new transaction every cycle.
    assign busy = 1'b0;

    armik_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    armik_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_cmd   (i_cmd),
        .o_valid (w_cordic_valid),
        .o_vec   (w_cordic_vec),
        .o_side  (w_cordic_side)
    );

    armik_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_cordic_valid),
        .i_vec    (w_cordic_vec),
        .i_side   (w_cordic_side),
        .i_cfg    (w_cfg),
        .o_valid  (o_done),
        .o_result (o_result)
    );

endmodule
